### hdl/mqms_pkg.sv
// Shared types and constants of the multi-queue message store.
`timescale 1ns / 1ps

package mqms_pkg;

  localparam int QID_W      = 3;
  localparam int SIZE_W     = 16;
  localparam int MSG_PORT_W = 32;
  localparam int STATUS_W   = 4;
  localparam int REQ_W      = 2;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [REQ_W-1:0] {
    REQ_CREATE = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_POST   = 2'd2,
    REQ_TAKE   = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 4'd0,
    STATUS_INVALID = 4'd1,
    STATUS_SIZE    = 4'd2,
    STATUS_NOFREE  = 4'd3,
    STATUS_WAITING = 4'd4,
    STATUS_NULL    = 4'd5,
    STATUS_FULL    = 4'd6,
    STATUS_EMPTY   = 4'd7,
    STATUS_HANDED  = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ_MSG
  } state_t;

endpackage

### hdl/multi_queue_message_store_core.sv
// Top level of the multi-queue message store: request decode, queue descriptors and message RAM.
`timescale 1ns / 1ps

// Requests arrive on the s_axis channel, one beat per request, and each request
// gives exactly one result beat on the m_axis channel.
// A create, delete or post request has its result loaded into the output register
// from its decision step, which follows the descriptor read, and the next request
// can be accepted once the block is back in idle. A take needs a further step,
// because the message address comes from the queue descriptor read first and
// the message RAM is then read in a second step.
// Only one request is in flight at a time: the descriptor RAM read, the
// decision and its write-back, and for a take the message RAM read, run in turn.
// The next request is accepted as soon as the previous one has been resolved,
// even while its result still waits in the output register.
// If the receiver stalls, the finished result is held in the output register and a
// following request waits in its decision step (a take in its message read step) until that register frees.
// Reset empties the output register and restores the free list to queues 0 to
// NUM_QUEUES-1 in order; descriptors read as freshly reset until first written,
// so no clearing pass is needed and requests are accepted straight after reset.
module multi_queue_message_store_core
  import mqms_pkg::*;
#(
  parameter int NUM_QUEUES = 8,
  parameter int MAX_DEPTH  = 16,
  parameter int MSG_WIDTH  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // queue_id[2:0], queue_size[18:3], message[50:19], waiter_present[51], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // req_type[1:0]
  input  logic [REQ_W-1:0]      s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // status[3:0], result_queue[6:4], taken_message[38:7], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int QW      = $clog2(NUM_QUEUES + 1);
  localparam int QIW     = NUM_QUEUES > 1 ? $clog2(NUM_QUEUES) : 1;
  localparam int DW      = $clog2(MAX_DEPTH + 1);
  localparam int IW      = MAX_DEPTH > 1 ? $clog2(MAX_DEPTH) : 1;
  localparam int MDEPTH  = NUM_QUEUES * MAX_DEPTH;
  localparam int AW      = MDEPTH > 1 ? $clog2(MDEPTH) : 1;
  localparam int STORE_W = MSG_WIDTH < MSG_PORT_W ? MSG_WIDTH : MSG_PORT_W;
  localparam int QCMP    = QW > QID_W ? QW : QID_W;

  typedef struct packed {
    logic          live;
    logic [QW-1:0] link;
    logic [IW-1:0] wr_idx;
    logic [IW-1:0] rd_idx;
    logic [DW-1:0] count;
    logic [DW-1:0] cap;
  } qdesc_t;

  localparam int DESC_W = $bits(qdesc_t);

  state_t state, state_next;

  req_t               req_type;
  logic [QID_W-1:0]   req_qid;
  logic [SIZE_W-1:0]  req_size;
  logic [STORE_W-1:0] req_msg;
  logic               req_waiter;
  logic [QIW-1:0]     cur_q;

  logic [QW-1:0]      free_head, free_head_next;
  logic [NUM_QUEUES-1:0] desc_vld;

  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [QID_W-1:0]     out_rq;
  logic [MSG_PORT_W-1:0] out_taken;

  logic               in_accept;
  logic               slot_free;
  logic               desc_re, desc_we;
  logic [QIW-1:0]     desc_raddr;
  qdesc_t             desc_rdata, desc_cur, desc_wdata, desc_reset;
  logic               msg_we, msg_re;
  logic [AW-1:0]      msg_addr;
  logic [STORE_W-1:0] msg_rdata;

  logic               out_load;
  status_t            load_status;
  logic [QID_W-1:0]   load_rq;
  logic [MSG_PORT_W-1:0] load_taken;

  status_t            dec_status;
  logic               dec_write;
  logic               dec_take_ok;
  logic               dec_msg_write;
  logic               free_update;
  qdesc_t             dec_desc;
  logic               q_ok;
  logic [DW-1:0]      idx_inc;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W - STATUS_W - QID_W - MSG_PORT_W){1'b0}},
                          out_taken, out_rq, out_status};

  assign desc_raddr = (s_axis_tuser == REQ_CREATE) ? QIW'(free_head)
                                                   : QIW'(s_axis_tdata[QID_W-1:0]);

  always_comb begin
    desc_reset        = '0;
    desc_reset.link   = QW'(cur_q) + QW'(1);
    desc_cur          = desc_vld[cur_q] ? desc_rdata : desc_reset;
  end

  assign q_ok = (QCMP'(req_qid) < QCMP'(NUM_QUEUES)) && desc_cur.live;

  mqms_ram #(
    .WIDTH(DESC_W),
    .DEPTH(NUM_QUEUES)
  ) u_desc_ram (
    .clk  (clk),
    .we   (desc_we),
    .waddr(cur_q),
    .wdata(desc_wdata),
    .re   (desc_re),
    .raddr(desc_raddr),
    .rdata(desc_rdata)
  );

  mqms_ram #(
    .WIDTH(STORE_W),
    .DEPTH(MDEPTH)
  ) u_msg_ram (
    .clk  (clk),
    .we   (msg_we),
    .waddr(msg_addr),
    .wdata(req_msg),
    .re   (msg_re),
    .raddr(msg_addr),
    .rdata(msg_rdata)
  );

  // Decision on the request held in the input registers, from the descriptor just read.
  always_comb begin
    dec_status    = STATUS_OK;
    dec_write     = 1'b0;
    dec_take_ok   = 1'b0;
    dec_msg_write = 1'b0;
    free_update   = 1'b0;
    dec_desc      = desc_cur;
    idx_inc       = '0;
    free_head_next = free_head;
    msg_addr      = AW'(cur_q) * AW'(MAX_DEPTH) + AW'(desc_cur.wr_idx);
    unique case (req_type)
      REQ_CREATE: begin
        if (req_size > SIZE_W'(MAX_DEPTH)) begin
          dec_status = STATUS_SIZE;
        end else if (free_head == QW'(NUM_QUEUES)) begin
          dec_status = STATUS_NOFREE;
        end else begin
          dec_write       = 1'b1;
          free_update     = 1'b1;
          free_head_next  = desc_cur.link;
          dec_desc.live   = 1'b1;
          dec_desc.wr_idx = '0;
          dec_desc.rd_idx = '0;
          dec_desc.count  = '0;
          dec_desc.cap    = DW'(req_size);
        end
      end
      REQ_DELETE: begin
        if (!q_ok) begin
          dec_status = STATUS_INVALID;
        end else if (req_waiter) begin
          dec_status = STATUS_WAITING;
        end else begin
          dec_write      = 1'b1;
          free_update    = 1'b1;
          free_head_next = QW'(cur_q);
          dec_desc.live  = 1'b0;
          dec_desc.link  = free_head;
        end
      end
      REQ_POST: begin
        if (req_msg == '0) begin
          dec_status = STATUS_NULL;
        end else if (!q_ok) begin
          dec_status = STATUS_INVALID;
        end else if (req_waiter) begin
          dec_status = STATUS_HANDED;
        end else if (desc_cur.count >= desc_cur.cap) begin
          dec_status = STATUS_FULL;
        end else begin
          dec_write       = 1'b1;
          dec_msg_write   = 1'b1;
          idx_inc         = DW'(desc_cur.wr_idx) + DW'(1);
          dec_desc.count  = desc_cur.count + DW'(1);
          dec_desc.wr_idx = (idx_inc >= desc_cur.cap) ? '0 : IW'(idx_inc);
        end
      end
      REQ_TAKE: begin
        msg_addr = AW'(cur_q) * AW'(MAX_DEPTH) + AW'(desc_cur.rd_idx);
        if (!q_ok) begin
          dec_status = STATUS_INVALID;
        end else if (desc_cur.count == '0) begin
          dec_status = STATUS_EMPTY;
        end else begin
          dec_write       = 1'b1;
          dec_take_ok     = 1'b1;
          idx_inc         = DW'(desc_cur.rd_idx) + DW'(1);
          dec_desc.count  = desc_cur.count - DW'(1);
          dec_desc.rd_idx = (idx_inc >= desc_cur.cap) ? '0 : IW'(idx_inc);
        end
      end
      default: begin
        dec_status = STATUS_INVALID;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (dec_take_ok) begin
          state_next = ST_READ_MSG;
        end else if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_READ_MSG: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    desc_re       = 1'b0;
    desc_we       = 1'b0;
    desc_wdata    = dec_desc;
    msg_we        = 1'b0;
    msg_re        = 1'b0;
    out_load      = 1'b0;
    load_status   = dec_status;
    load_rq       = '0;
    load_taken    = '0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = !rst;
        desc_re       = s_axis_tvalid;
      end
      ST_EXEC: begin
        if (dec_take_ok) begin
          desc_we = 1'b1;
          msg_re  = 1'b1;
        end else if (slot_free) begin
          desc_we  = dec_write;
          msg_we   = dec_msg_write;
          out_load = 1'b1;
          if (req_type == REQ_CREATE && dec_status == STATUS_OK) begin
            load_rq = QID_W'(cur_q);
          end
        end
      end
      ST_READ_MSG: begin
        out_load    = slot_free;
        load_status = STATUS_OK;
        load_taken  = MSG_PORT_W'(msg_rdata);
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      free_head <= '0;
      desc_vld  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (desc_we) begin
        desc_vld[cur_q] <= 1'b1;
      end
      if (desc_we && free_update) begin
        free_head <= free_head_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_type   <= req_t'(s_axis_tuser);
      req_qid    <= s_axis_tdata[QID_W-1:0];
      req_size   <= s_axis_tdata[QID_W +: SIZE_W];
      req_msg    <= s_axis_tdata[QID_W + SIZE_W +: STORE_W];
      req_waiter <= s_axis_tdata[QID_W + SIZE_W + MSG_PORT_W];
      cur_q      <= desc_raddr;
    end
    if (out_load) begin
      out_status <= load_status;
      out_rq     <= load_rq;
      out_taken  <= load_taken;
    end
  end

  assert property (@(posedge clk) disable iff (rst) free_head <= QW'(NUM_QUEUES))
    else $error("free list head beyond the pool");

  assert property (@(posedge clk) disable iff (rst) in_accept |=> !s_axis_tready)
    else $error("second request accepted while one is in flight");

  assert property (@(posedge clk) disable iff (rst)
                   (m_axis_tvalid && m_axis_tdata[STATUS_W-1:0] != STATUS_OK) |->
                   (m_axis_tdata[STATUS_W +: QID_W + MSG_PORT_W] == '0))
    else $error("refused request carries a queue number or message");

  assert property (@(posedge clk) disable iff (rst) (desc_we || msg_we) |-> state == ST_EXEC)
    else $error("state written outside the decision step");

endmodule

### hdl/mqms_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module mqms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
